>>> hdl/mrd_pkg.sv
// Shared types, constants and the CRC-16 byte update for the Modbus RTU response deframer.
// Used by mrd_deframe_core and modbus_rtu_response_deframer; depends on nothing else.

package mrd_pkg;

   // Window that must fill before a frame start is judged.
   localparam int unsigned MIN_WINDOW = 7;
   localparam logic [2:0] LAST_POS = 3'(MIN_WINDOW - 1);

   // Function codes that can start a response frame.
   localparam logic [7:0] FC_READ  = 8'h03;
   localparam logic [7:0] FC_WRITE = 8'h06;

   // Frame sizes.
   localparam logic [8:0] READ_OVERHEAD = 9'd5;
   localparam logic [8:0] WRITE_LENGTH  = 9'd8;
   localparam logic [8:0] WINDOW_LENGTH = 9'(MIN_WINDOW);

   // Modbus CRC-16: reflected polynomial, all-ones start value.
   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;

   // Address byte after reset.
   localparam logic [7:0] SLAVE_ADDRESS_RESET = 8'h1C;

   typedef enum logic [1:0] {
      ST_READ_OK    = 2'd0,
      ST_WRITE_OK   = 2'd1,
      ST_CRC_ERROR  = 2'd2,
      ST_SHORT_DROP = 2'd3
   } status_type;

   typedef struct packed {
      logic       valid;
      status_type status;
      logic [15:0] value;
      logic [8:0]  length;
   } result_type;

   // One byte through the CRC, least significant bit first.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
      logic [15:0] c;
      c = crc_in ^ {8'h00, data};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

>>> hdl/mrd_deframe_core.sv
// Window, frame tracking and CRC check of the Modbus RTU response deframer.
// Depends on mrd_pkg; the result is combinational and is registered by the top level.

module mrd_deframe_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          rx_byte,
   input  logic [7:0]          slave_address,
   output mrd_pkg::result_type result
);

   localparam int unsigned W = mrd_pkg::MIN_WINDOW;

   // Window bytes and, for every start position, the CRC over its first five and six bytes.
   logic [7:0]  win_ff  [W];
   logic [7:0]  win_in  [W];
   logic [15:0] crc5_ff [W];
   logic [15:0] crc5_in [W];
   logic [15:0] crc6_ff [W];
   logic [15:0] crc6_in [W];
   logic [7:0]  win_upd [W];
   logic [15:0] crc5_upd[W];
   logic [15:0] crc6_upd[W];

   logic [2:0]  fill_ff, fill_in;
   logic        committed_ff, committed_in;
   logic [8:0]  rem_ff, rem_in;
   logic [8:0]  total_ff, total_in;
   logic [15:0] crc_ff, crc_in;
   logic [15:0] held_ff, held_in;
   logic        is_read_ff, is_read_in;
   logic [7:0]  crc_low_ff, crc_low_in;

   logic [7:0]  fn;
   logic        addr_ok;
   logic        fn_ok;
   logic [8:0]  frame_len;
   logic [15:0] got_crc;
   logic [15:0] init_crc;

   // Window contents once the incoming byte is written at the fill position.
   always_comb begin
      init_crc = mrd_pkg::crc_byte(mrd_pkg::CRC_INIT, rx_byte);
      for (int k = 0; k < W; k++) begin
         if (3'(k) == fill_ff) begin
            win_upd[k]  = rx_byte;
            crc5_upd[k] = init_crc;
            crc6_upd[k] = init_crc;
         end else if (3'(k) < fill_ff) begin
            win_upd[k]  = win_ff[k];
            crc5_upd[k] = ({1'b0, fill_ff} < 4'(k + 5)) ?
                          mrd_pkg::crc_byte(crc5_ff[k], rx_byte) : crc5_ff[k];
            crc6_upd[k] = ({1'b0, fill_ff} < 4'(k + 6)) ?
                          mrd_pkg::crc_byte(crc6_ff[k], rx_byte) : crc6_ff[k];
         end else begin
            win_upd[k]  = win_ff[k];
            crc5_upd[k] = crc5_ff[k];
            crc6_upd[k] = crc6_ff[k];
         end
      end
   end

   // Judgment of a full window.
   assign fn        = win_upd[1];
   assign addr_ok   = (win_upd[0] == slave_address);
   assign fn_ok     = (fn == mrd_pkg::FC_READ) || (fn == mrd_pkg::FC_WRITE);
   assign frame_len = (fn == mrd_pkg::FC_READ) ?
                      mrd_pkg::READ_OVERHEAD + {1'b0, win_upd[2]} : mrd_pkg::WRITE_LENGTH;

   // Received CRC: the high byte is always the incoming one.
   assign got_crc = committed_ff ? {rx_byte, crc_low_ff} : {rx_byte, win_upd[5]};

   // Next state and result for one item.
   always_comb begin
      win_in       = win_ff;
      crc5_in      = crc5_ff;
      crc6_in      = crc6_ff;
      fill_in      = fill_ff;
      committed_in = committed_ff;
      rem_in       = rem_ff;
      total_in     = total_ff;
      crc_in       = crc_ff;
      held_in      = held_ff;
      is_read_in   = is_read_ff;
      crc_low_in   = crc_low_ff;
      result       = '0;
      result.status = mrd_pkg::ST_READ_OK;

      if (step) begin
         if (committed_ff) begin
            // Bytes past the window go straight into the frame.
            if (rem_ff > 9'd2) begin
               crc_in = mrd_pkg::crc_byte(crc_ff, rx_byte);
               rem_in = rem_ff - 9'd1;
            end else if (rem_ff == 9'd2) begin
               crc_low_in = rx_byte;
               rem_in     = 9'd1;
            end else begin
               result.valid  = 1'b1;
               result.length = total_ff;
               if (got_crc != crc_ff) begin
                  result.status = mrd_pkg::ST_CRC_ERROR;
               end else if (is_read_ff) begin
                  result.status = mrd_pkg::ST_READ_OK;
                  result.value  = held_ff;
               end else begin
                  result.status = mrd_pkg::ST_WRITE_OK;
               end
               committed_in = 1'b0;
               rem_in       = 9'd0;
               fill_in      = 3'd0;
            end
         end else if (fill_ff != mrd_pkg::LAST_POS) begin
            // Window still filling.
            win_in  = win_upd;
            crc5_in = crc5_upd;
            crc6_in = crc6_upd;
            fill_in = fill_ff + 3'd1;
         end else if (!addr_ok || !fn_ok) begin
            // No frame start here: drop the oldest byte.
            for (int k = 0; k < W - 1; k++) begin
               win_in[k]  = win_upd[k + 1];
               crc5_in[k] = crc5_upd[k + 1];
               crc6_in[k] = crc6_upd[k + 1];
            end
            fill_in = mrd_pkg::LAST_POS;
         end else if (frame_len < mrd_pkg::WINDOW_LENGTH) begin
            // Read reply with too small a byte count: drop it unchecked.
            result.valid  = 1'b1;
            result.status = mrd_pkg::ST_SHORT_DROP;
            result.length = frame_len;
            if (frame_len == mrd_pkg::READ_OVERHEAD) begin
               win_in[0]  = win_upd[5];
               win_in[1]  = win_upd[6];
               crc5_in[0] = crc5_upd[5];
               crc5_in[1] = crc5_upd[6];
               crc6_in[0] = crc6_upd[5];
               crc6_in[1] = crc6_upd[6];
               fill_in    = 3'd2;
            end else begin
               win_in[0]  = win_upd[6];
               crc5_in[0] = crc5_upd[6];
               crc6_in[0] = crc6_upd[6];
               fill_in    = 3'd1;
            end
         end else if (frame_len == mrd_pkg::WINDOW_LENGTH) begin
            // Seven-byte frame is complete with the window.
            result.valid  = 1'b1;
            result.length = frame_len;
            if (got_crc == crc5_ff[0]) begin
               result.status = mrd_pkg::ST_READ_OK;
               result.value  = {win_upd[3], win_upd[4]};
            end else begin
               result.status = mrd_pkg::ST_CRC_ERROR;
            end
            fill_in = 3'd0;
         end else begin
            // Longer frame: commit and continue past the window.
            committed_in = 1'b1;
            total_in     = frame_len;
            is_read_in   = (fn == mrd_pkg::FC_READ);
            held_in      = {win_upd[3], win_upd[4]};
            fill_in      = 3'd0;
            crc_low_in   = rx_byte;
            if (frame_len == mrd_pkg::WRITE_LENGTH) begin
               crc_in = crc6_ff[0];
               rem_in = 9'd1;
            end else begin
               crc_in = mrd_pkg::crc_byte(crc6_ff[0], rx_byte);
               rem_in = frame_len - mrd_pkg::WINDOW_LENGTH;
            end
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= 3'd0;
         committed_ff <= 1'b0;
         rem_ff       <= 9'd0;
      end else begin
         fill_ff      <= fill_in;
         committed_ff <= committed_in;
         rem_ff       <= rem_in;
      end
   end

   // Payload state.
   always_ff @(posedge clock) begin
      win_in_loop : for (int k = 0; k < W; k++) begin
         win_ff[k]  <= win_in[k];
         crc5_ff[k] <= crc5_in[k];
         crc6_ff[k] <= crc6_in[k];
      end
      total_ff   <= total_in;
      crc_ff     <= crc_in;
      held_ff    <= held_in;
      is_read_ff <= is_read_in;
      crc_low_ff <= crc_low_in;
   end

   // A committed frame always has bytes left and starts with an empty window.
   a_commit_count : assert property (@(posedge clock) disable iff (reset)
      committed_ff |-> (rem_ff != 9'd0) && (rem_ff <= total_ff) && (fill_ff == 3'd0))
      else $error("committed frame with bad remaining count or window fill");

   // The window never holds a full seven bytes between items.
   a_fill_range : assert property (@(posedge clock) disable iff (reset)
      fill_ff <= mrd_pkg::LAST_POS)
      else $error("window fill out of range");

   // A dropped short frame is five or six bytes long.
   a_short_len : assert property (@(posedge clock) disable iff (reset)
      (result.valid && result.status == mrd_pkg::ST_SHORT_DROP) |->
      (result.length == 9'd5 || result.length == 9'd6))
      else $error("short drop with wrong length");

   // Only a good read reply carries a value.
   a_value_zero : assert property (@(posedge clock) disable iff (reset)
      (result.valid && result.status != mrd_pkg::ST_READ_OK) |-> (result.value == 16'h0000))
      else $error("value present on a result other than a good read");

   // A finished frame clears the commitment on the next edge.
   a_frame_end : assert property (@(posedge clock) disable iff (reset)
      (result.valid && committed_ff) |=> !committed_ff)
      else $error("frame still committed after its result");

endmodule

>>> hdl/modbus_rtu_response_deframer.sv
// Modbus RTU response deframer: input register, deframing core and result register.
// Depends on mrd_pkg and mrd_deframe_core.
//
// Usage:
//   req_* carries one received serial byte per item. rsp_* carries at most one result
//   per byte: a good read value, a good write echo, a CRC error or a dropped short frame,
//   with the number of bytes the frame occupied. csr_wen/csr_wdata set the slave address
//   that a response must start with; write it only while the block is idle.
// Throughput and data path:
//   One item per cycle sustained while no result is held. An accepted byte waits in the
//   input register until the result register can take the core's output; the core then
//   processes it, with its per-byte CRC update and window shift, and its result is
//   registered and presented on rsp_*.
// Reset:
//   Synchronous. Clears the window, drops any frame in progress, empties both registers
//   and sets the slave address to 0x1C.
// Stalls:
//   A held result blocks the core; the input register then holds its byte and req_tready
//   drops, so nothing is lost. A result taken in the same cycle frees the slot at once.

module modbus_rtu_response_deframer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [1:0] status, [17:2] register_value, [26:18] frame_length
   input  logic        csr_wen,
   input  logic [7:0]  csr_wdata
);

   logic                in_valid_ff, in_valid_in;
   logic [7:0]          in_byte_ff, in_byte_in;
   logic [7:0]          slave_address_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   mrd_pkg::result_type rsp_data_ff, rsp_data_in;
   mrd_pkg::result_type result;
   logic                out_free;
   logic                fire;

   // Slave address register.
   always_ff @(posedge clock) begin
      if (reset) begin
         slave_address_ff <= mrd_pkg::SLAVE_ADDRESS_RESET;
      end else if (csr_wen) begin
         slave_address_ff <= csr_wdata;
      end
   end

   // Handshake between the two registers.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || fire;

   // Input register.
   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_byte_in  = req_tdata;
      end
   end

   mrd_deframe_core u_core (
      .clock         (clock),
      .reset         (reset),
      .step          (fire),
      .rx_byte       (in_byte_ff),
      .slave_address (slave_address_ff),
      .result        (result)
   );

   // Result register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (fire && result.valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b00000, rsp_data_ff.length, rsp_data_ff.value, rsp_data_ff.status};

   // The core only advances when the result register can take its output.
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !fire)
      else $error("core advanced while a result was held");

   // A held input byte is processed before a new one is taken.
   a_in_hold : assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !fire) |=> (in_valid_ff && $stable(in_byte_ff)))
      else $error("input byte lost while stalled");

   // A result is loaded only from a core step that produced one.
   a_rsp_source : assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff && !(fire && result.valid)) |=> !rsp_valid_ff)
      else $error("result appeared without a producing step");

endmodule
